// File: rtl/linear_probe_hash_set_defines.svh
// Shared assertion macros for the hash set checker.
`ifndef LINEAR_PROBE_HASH_SET_DEFINES_SVH
`define LINEAR_PROBE_HASH_SET_DEFINES_SVH

// Same-cycle implication, clocked on clk, quiet while in reset.
`define LPHS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, quiet while in reset.
`define LPHS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lphs_pkg.sv
package lphs_pkg;

    localparam int KEY_W    = 31;
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 4;

    // home-slot remainder: digit width in key bits and number of digit steps
    localparam int DIGIT_W   = 4;
    localparam int MOD_STEPS = (KEY_W + DIGIT_W - 1) / DIGIT_W;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FIND   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_MISS = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_CHECK,
        ST_DONE
    } lphs_state_t;

    typedef struct packed {
        logic             used;
        logic             deleted;
        logic [KEY_W-1:0] key;
    } lphs_entry_t;

endpackage

// File: rtl/lphs_ram.sv
module lphs_ram #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 11
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: rtl/lphs_mod.sv
// Key mod MODULUS, restoring remainder, DIGIT_W key bits per cycle.
module lphs_mod #(
    parameter int MODULUS = 11
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lphs_pkg::KEY_W-1:0]   key,
    output logic                         done,
    output logic [$clog2(MODULUS)-1:0]   rem
);

    localparam int REM_W   = $clog2(MODULUS);
    localparam int DIGIT_W = lphs_pkg::DIGIT_W;
    localparam int STEPS   = lphs_pkg::MOD_STEPS;
    localparam int PAD_W   = STEPS * DIGIT_W;
    localparam int CNT_W   = $clog2(STEPS);
    localparam logic [REM_W:0] MOD_WIDE = (REM_W + 1)'(MODULUS);

    logic [PAD_W-1:0] sh_reg, sh_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [REM_W-1:0] acc;
    logic [REM_W:0]   trial;

    // DIGIT_W chained compare-subtract steps on the narrow remainder
    always_comb
    begin
        acc   = rem_reg;
        trial = '0;
        for (int i = 0; i < DIGIT_W; i++)
        begin
            trial = {acc, sh_reg[PAD_W-1-i]};
            if (trial >= MOD_WIDE)
            begin
                trial = trial - MOD_WIDE;
            end
            acc = trial[REM_W-1:0];
        end
    end

    always_comb
    begin
        sh_next   = sh_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            sh_next   = PAD_W'(key);
            rem_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            sh_next  = sh_reg << DIGIT_W;
            rem_next = acc;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        rem_reg <= rem_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: rtl/linear_probe_hash_set.sv
// Flow: the home-slot remainder, then p probes (1 to TABLE_SIZE, one table read each),
// then the output register; a full-table insert or an unused kind goes straight there.
// One request in flight: the next beat is taken only once the result is in the output
// register, and later while the result side stalls; the remainder and the probes set this.
// Reset: asynchronous, active low; the table is then swept clear, slot by slot,
// with in_stall held high until the sweep ends.
module linear_probe_hash_set #(
    parameter int TABLE_SIZE = 11
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // request channel
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lphs_pkg::KIND_W-1:0]     kind,
    input  logic [lphs_pkg::KEY_W-1:0]      key_value,
    // result channel
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lphs_pkg::STATUS_W-1:0]   status,
    output logic [lphs_pkg::SLOT_W-1:0]     slot
);

    localparam int IDX_W    = $clog2(TABLE_SIZE);
    localparam int CNT_W    = $clog2(TABLE_SIZE + 1);
    localparam int SLOT_W   = lphs_pkg::SLOT_W;
    localparam int ENTRY_W  = $bits(lphs_pkg::lphs_entry_t);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_SIZE);

    lphs_pkg::lphs_state_t state_reg, state_next;

    // sweep pointer for the clearing pass
    logic [IDX_W-1:0] clr_reg, clr_next;
    // live keys: used and not marked deleted
    logic [CNT_W-1:0] live_reg, live_next;

    // current request
    logic [lphs_pkg::KIND_W-1:0] kind_reg, kind_next;
    logic [lphs_pkg::KEY_W-1:0]  key_reg, key_next;

    // probe walk: current slot, home slot, slots passed so far
    logic [IDX_W-1:0] s_reg, s_next;
    logic [IDX_W-1:0] home_reg, home_next;
    logic [IDX_W-1:0] n_reg, n_next;

    // result held until the output register is free
    logic [lphs_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [IDX_W-1:0]              res_slot_reg, res_slot_next;

    // output register
    logic                          out_valid_reg, out_valid_next;
    logic [lphs_pkg::STATUS_W-1:0] out_status_reg, out_status_next;
    logic [SLOT_W-1:0]             out_slot_reg, out_slot_next;

    // table memory and remainder unit
    logic                  ram_wr_en;
    logic [IDX_W-1:0]      ram_wr_addr;
    lphs_pkg::lphs_entry_t ram_wr_entry;
    logic [IDX_W-1:0]      ram_rd_addr;
    logic [ENTRY_W-1:0]    ram_rd_data;
    lphs_pkg::lphs_entry_t rd_entry;
    logic                  mod_start;
    logic                  mod_done;
    logic [IDX_W-1:0]      mod_rem;

    // probe evaluation
    logic [IDX_W-1:0] s_nx;
    logic             key_match;
    logic             probe_stop;
    logic             probe_end;
    logic             probe_ok;

    logic accept;
    logic out_free;
    logic table_full;
    logic kind_known;

    lphs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ENTRY_W'(ram_wr_entry)),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    lphs_mod #(
        .MODULUS (TABLE_SIZE)
    ) u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mod_start),
        .key   (key_value),
        .done  (mod_done),
        .rem   (mod_rem)
    );

    assign rd_entry = lphs_pkg::lphs_entry_t'(ram_rd_data);

    // Only the idle state takes a beat: one request in flight at a time.
    assign in_stall   = (state_reg != lphs_pkg::ST_IDLE);
    assign accept     = in_valid && !in_stall;
    // Output register can load when empty or being emptied this cycle.
    assign out_free   = !out_valid_reg || !out_stall;
    assign table_full = (live_reg >= FULL_CNT);
    assign kind_known = (kind == lphs_pkg::KIND_INSERT) || (kind == lphs_pkg::KIND_FIND)
                        || (kind == lphs_pkg::KIND_DELETE);

    // Probe decision on the entry read for s_reg.
    always_comb
    begin
        s_nx       = (s_reg == LAST_IDX) ? '0 : s_reg + 1'b1;
        key_match  = rd_entry.used && (rd_entry.key == key_reg);
        probe_stop = !rd_entry.used || (rd_entry.key == key_reg);
        if (kind_reg == lphs_pkg::KIND_INSERT)
        begin
            // first empty or deleted slot; give up after the whole table
            probe_ok  = !rd_entry.used || rd_entry.deleted;
            probe_end = probe_ok || (n_reg == LAST_IDX);
        end
        else
        begin
            // stop on the key, an empty slot or back at home; a deleted copy still stops
            probe_ok  = probe_stop && key_match && !rd_entry.deleted;
            probe_end = probe_stop || (s_nx == home_reg);
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lphs_pkg::ST_CLEAR:
            begin
                if (clr_reg == LAST_IDX)
                begin
                    state_next = lphs_pkg::ST_IDLE;
                end
            end
            lphs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if ((kind == lphs_pkg::KIND_INSERT) && table_full)
                    begin
                        state_next = lphs_pkg::ST_DONE;
                    end
                    else if (kind_known)
                    begin
                        state_next = lphs_pkg::ST_HOME;
                    end
                    else
                    begin
                        state_next = lphs_pkg::ST_DONE;
                    end
                end
            end
            lphs_pkg::ST_HOME:
            begin
                if (mod_done)
                begin
                    state_next = lphs_pkg::ST_CHECK;
                end
            end
            lphs_pkg::ST_CHECK:
            begin
                if (probe_end)
                begin
                    state_next = lphs_pkg::ST_DONE;
                end
            end
            lphs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = lphs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lphs_pkg::ST_IDLE;
            end
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        clr_next        = clr_reg;
        live_next       = live_reg;
        kind_next       = kind_reg;
        key_next        = key_reg;
        s_next          = s_reg;
        home_next       = home_reg;
        n_next          = n_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_valid_next  = out_valid_reg && out_stall;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = s_reg;
        ram_wr_entry    = '0;
        // in CHECK the next slot is fetched ahead so the probe walk never waits on a read
        ram_rd_addr     = s_nx;
        mod_start       = 1'b0;

        case (state_reg)
            lphs_pkg::ST_CLEAR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                clr_next    = clr_reg + 1'b1;
            end
            lphs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next     = kind;
                    key_next      = key_value;
                    res_slot_next = '0;
                    if ((kind == lphs_pkg::KIND_INSERT) && table_full)
                    begin
                        res_status_next = lphs_pkg::STATUS_FULL;
                    end
                    else if (kind_known)
                    begin
                        mod_start = 1'b1;
                    end
                    else
                    begin
                        res_status_next = lphs_pkg::STATUS_MISS;
                    end
                end
            end
            lphs_pkg::ST_HOME:
            begin
                ram_rd_addr = mod_rem;
                if (mod_done)
                begin
                    s_next    = mod_rem;
                    home_next = mod_rem;
                    n_next    = '0;
                end
            end
            lphs_pkg::ST_CHECK:
            begin
                if (probe_end)
                begin
                    if (probe_ok)
                    begin
                        res_status_next      = lphs_pkg::STATUS_OK;
                        res_slot_next        = s_reg;
                        ram_wr_en            = (kind_reg == lphs_pkg::KIND_INSERT)
                                               || (kind_reg == lphs_pkg::KIND_DELETE);
                        ram_wr_entry.used    = 1'b1;
                        ram_wr_entry.key     = key_reg;
                        if (kind_reg == lphs_pkg::KIND_INSERT)
                        begin
                            ram_wr_entry.deleted = 1'b0;
                            live_next            = live_reg + 1'b1;
                        end
                        else if (kind_reg == lphs_pkg::KIND_DELETE)
                        begin
                            ram_wr_entry.deleted = 1'b1;
                            if (live_reg != '0)
                            begin
                                live_next = live_reg - 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        res_status_next = (kind_reg == lphs_pkg::KIND_INSERT)
                                          ? lphs_pkg::STATUS_FULL : lphs_pkg::STATUS_MISS;
                        res_slot_next   = '0;
                    end
                end
                else
                begin
                    s_next = s_nx;
                    n_next = n_reg + 1'b1;
                end
            end
            lphs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = SLOT_W'(res_slot_reg);
                end
            end
            default:
            begin
                mod_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lphs_pkg::ST_CLEAR;
            clr_reg       <= '0;
            live_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            live_reg      <= live_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg       <= kind_next;
        key_reg        <= key_next;
        s_reg          <= s_next;
        home_reg       <= home_next;
        n_reg          <= n_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = out_status_reg;
    assign slot      = out_slot_reg;

endmodule

// File: rtl/lphs_chk.sv
`include "linear_probe_hash_set_defines.svh"

module lphs_chk #(
    parameter int TABLE_SIZE = 11
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_stall,
    input logic                          out_valid,
    input logic                          out_stall,
    input logic [lphs_pkg::STATUS_W-1:0] status,
    input logic [lphs_pkg::SLOT_W-1:0]   slot
);

    // a held result beat keeps its payload
    `LPHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(status) && $stable(slot), "result beat changed while stalled")

    // failed operations report slot zero
    `LPHS_ASSERT_SAME(a_fail_slot, out_valid && (status != lphs_pkg::STATUS_OK), slot == '0, "non-zero slot on failure")

    // a success names a slot inside the table
    `LPHS_ASSERT_SAME(a_ok_range, out_valid && (status == lphs_pkg::STATUS_OK), 32'(slot) < TABLE_SIZE, "slot beyond table")

    // one request in flight: a taken beat closes the input
    `LPHS_ASSERT_NEXT(a_one_busy, in_valid && !in_stall, in_stall, "input open after a beat")

    // a new result only appears while a request is being worked
    `LPHS_ASSERT_SAME(a_res_cause, $rose(out_valid), $past(in_stall), "result beat with no request in flight")

endmodule

bind linear_probe_hash_set lphs_chk #(.TABLE_SIZE(TABLE_SIZE)) u_lphs_chk (.*);

// File: tb/linear_probe_hash_set_checker.sv
module linear_probe_hash_set_checker
    import lphs_pkg::*;
#(
    parameter int TABLE_SIZE = 11
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic [KIND_W-1:0]   kind,
    input  logic [KEY_W-1:0]    key_value,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [SLOT_W-1:0]   slot,
    output int                  fail_count,
    output int                  pending,
    output int                  ok_count,
    output int                  full_count,
    output int                  miss_count
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
    } set_answer_t;

    // shadow of the table
    logic [KEY_W-1:0] stored_key [TABLE_SIZE];
    logic             slot_taken [TABLE_SIZE];
    logic             slot_dead  [TABLE_SIZE];
    int               live_keys;

    set_answer_t answer_queue [$];
    int          fail_tally;
    int          ok_tally;
    int          full_tally;
    int          miss_tally;

    function automatic int home_of(input logic [KEY_W-1:0] key);
        return int'({1'b0, key} % 32'(TABLE_SIZE));
    endfunction

    // probe for a live copy; stops at a match, an empty slot or back at home
    function automatic logic probe_live(input logic [KEY_W-1:0] key, output int pos);
        int  home;
        int  s;
        logic stop;
        home = home_of(key);
        s    = home;
        stop = 1'b0;
        for (int n = 0; n < TABLE_SIZE && !stop; n++)
        begin
            if (!slot_taken[s] || stored_key[s] == key)
                stop = 1'b1;
            else
            begin
                s = (s + 1 >= TABLE_SIZE) ? 0 : s + 1;
                if (s == home)
                    stop = 1'b1;
            end
        end
        pos = s;
        return slot_taken[s] && stored_key[s] == key && !slot_dead[s];
    endfunction

    function automatic set_answer_t apply_set_op(input logic [KIND_W-1:0] op,
                                                 input logic [KEY_W-1:0] key);
        set_answer_t ans;
        int          pos;
        int          s;
        logic        placed;
        ans.status = STATUS_MISS;
        ans.slot   = '0;
        case (op)
            KIND_INSERT:
            begin
                if (live_keys >= TABLE_SIZE)
                    ans.status = STATUS_FULL;
                else
                begin
                    s      = home_of(key);
                    placed = 1'b0;
                    for (int n = 0; n < TABLE_SIZE && !placed; n++)
                    begin
                        if (!slot_taken[s] || slot_dead[s])
                            placed = 1'b1;
                        else
                            s = (s + 1 >= TABLE_SIZE) ? 0 : s + 1;
                    end
                    if (placed)
                    begin
                        stored_key[s] = key;
                        slot_taken[s] = 1'b1;
                        slot_dead[s]  = 1'b0;
                        live_keys++;
                        ans.status = STATUS_OK;
                        ans.slot   = SLOT_W'(s);
                    end
                    else
                        ans.status = STATUS_FULL;
                end
            end
            KIND_FIND:
            begin
                if (probe_live(key, pos))
                begin
                    ans.status = STATUS_OK;
                    ans.slot   = SLOT_W'(pos);
                end
            end
            KIND_DELETE:
            begin
                if (probe_live(key, pos))
                begin
                    slot_dead[pos] = 1'b1;
                    if (live_keys > 0)
                        live_keys--;
                    ans.status = STATUS_OK;
                    ans.slot   = SLOT_W'(pos);
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        set_answer_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SIZE; i++)
            begin
                stored_key[i] = '0;
                slot_taken[i] = 1'b0;
                slot_dead[i]  = 1'b0;
            end
            live_keys = 0;
            answer_queue.delete();
            fail_tally = 0;
            ok_tally   = 0;
            full_tally = 0;
            miss_tally = 0;
            fail_count <= 0;
            pending    <= 0;
            ok_count   <= 0;
            full_count <= 0;
            miss_count <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (answer_queue.size() == 0)
                begin
                    $error("result beat with nothing outstanding: status %0d slot %0d",
                           status, slot);
                    fail_tally++;
                end
                else
                begin
                    want = answer_queue.pop_front();
                    if (status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, status);
                        fail_tally++;
                    end
                    if (slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, slot);
                        fail_tally++;
                    end
                    case (want.status)
                        STATUS_OK:   ok_tally++;
                        STATUS_FULL: full_tally++;
                        default:     miss_tally++;
                    endcase
                end
            end
            if (in_valid && !in_stall)
                answer_queue.push_back(apply_set_op(kind, key_value));
            fail_count <= fail_tally;
            pending    <= answer_queue.size();
            ok_count   <= ok_tally;
            full_count <= full_tally;
            miss_count <= miss_tally;
        end
    end

endmodule

// File: tb/linear_probe_hash_set_tb.sv
module linear_probe_hash_set_tb;
    import lphs_pkg::*;

    localparam int TABLE_SIZE   = 11;
    // extra wait after every answer is in; ample for a worst-case beat that probes every slot
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1925;
    localparam int BLOCK_ITEMS  = 150;
    localparam int POOL_N       = 16;
    // kind code the block has no operation for
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [KIND_W-1:0]   kind;
    logic [KEY_W-1:0]    key_value;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;

    int fail_count;
    int pending;
    int ok_count;
    int full_count;
    int miss_count;

    // set during the quiet stretch: neither side idles
    bit calm = 1'b0;

    int inserts_sent;
    int finds_sent;
    int deletes_sent;
    int unused_sent;
    int cycle_count;

    logic [KEY_W-1:0] key_pool [POOL_N];

    linear_probe_hash_set #(
        .TABLE_SIZE (TABLE_SIZE)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .key_value (key_value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .slot      (slot)
    );

    linear_probe_hash_set_checker #(
        .TABLE_SIZE (TABLE_SIZE)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .kind       (kind),
        .key_value  (key_value),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .slot       (slot),
        .fail_count (fail_count),
        .pending    (pending),
        .ok_count   (ok_count),
        .full_count (full_count),
        .miss_count (miss_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side back-pressure: a fresh coin every cycle, about one cycle
    // in five stalled, none during the calm stretch.
    always @(posedge clk)
        out_stall <= !calm && ($urandom_range(0, 99) < 21);

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // One request beat. Idle cycles go in front of the beat, each chosen
    // afresh, so valid only drops between beats. On return the beat has
    // been taken at the latest edge and valid is still high; the next call
    // either holds it high or lowers it, never both in one step.
    task automatic send_beat(input logic [KIND_W-1:0] op, input logic [KEY_W-1:0] key);
        while (!calm && $urandom_range(0, 99) < 21)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= op;
        key_value <= key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        case (op)
            KIND_INSERT: inserts_sent++;
            KIND_FIND:   finds_sent++;
            KIND_DELETE: deletes_sent++;
            default:     unused_sent++;
        endcase
    endtask

    // A fresh key pool per block: clusters on one home slot, small keys,
    // keys near the top of the range and full-width random ones.
    task automatic refill_pool();
        int home;
        home = $urandom_range(0, TABLE_SIZE - 1);
        for (int i = 0; i < POOL_N; i++)
        begin
            case ($urandom_range(0, 3))
                0:       key_pool[i] = KEY_W'(home + TABLE_SIZE * $urandom_range(0, 40));
                1:       key_pool[i] = KEY_W'($urandom);
                2:       key_pool[i] = KEY_W'($urandom_range(0, 30));
                default: key_pool[i] = {KEY_W{1'b1}} - KEY_W'($urandom_range(0, 30));
            endcase
        end
    endtask

    initial
    begin
        int w_ins;
        int w_find;
        int roll;
        logic [KIND_W-1:0] op;
        logic [KEY_W-1:0]  key;

        inserts_sent = 0;
        finds_sent   = 0;
        deletes_sent = 0;
        unused_sent  = 0;
        w_ins        = 35;
        w_find       = 30;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        kind      <= KIND_INSERT;
        key_value <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: duplicates, a deleted slot that still holds the key
        // ahead of a live copy, absent keys, the unused kind, a full table
        // and a wrap-around probe.
        send_beat(KIND_INSERT, '0);
        send_beat(KIND_INSERT, '0);
        send_beat(KIND_INSERT, KEY_W'(11));
        send_beat(KIND_INSERT, {KEY_W{1'b1}});
        send_beat(KIND_FIND,   '0);
        send_beat(KIND_DELETE, '0);
        send_beat(KIND_FIND,   '0);
        send_beat(KIND_FIND,   KEY_W'(11));
        send_beat(KIND_DELETE, KEY_W'(22));
        send_beat(KIND_UNUSED, KEY_W'(5));
        send_beat(KIND_INSERT, KEY_W'(22));
        send_beat(KIND_INSERT, KEY_W'(33));
        send_beat(KIND_INSERT, KEY_W'(44));
        send_beat(KIND_INSERT, KEY_W'(5));
        send_beat(KIND_INSERT, KEY_W'(16));
        send_beat(KIND_INSERT, KEY_W'(27));
        send_beat(KIND_INSERT, KEY_W'(100));
        send_beat(KIND_INSERT, KEY_W'(1000000));
        send_beat(KIND_INSERT, KEY_W'(7));
        send_beat(KIND_FIND,   KEY_W'(1234567));
        send_beat(KIND_FIND,   '0);
        send_beat(KIND_FIND,   {KEY_W{1'b1}});
        send_beat(KIND_DELETE, {KEY_W{1'b1}});
        send_beat(KIND_INSERT, {KEY_W{1'b1}} - 1'b1);

        // Random: each block picks filling, draining or a mix at random so
        // the live count swings between empty and full.
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i % BLOCK_ITEMS == 0)
            begin
                refill_pool();
                case ($urandom_range(0, 2))
                    0:       begin w_ins = 55; w_find = 20; end
                    1:       begin w_ins = 20; w_find = 25; end
                    default: begin w_ins = 35; w_find = 30; end
                endcase
            end
            calm = (i >= 800 && i < 1100);
            roll = $urandom_range(0, 99);
            if (roll < 5)
                op = KIND_UNUSED;
            else if (roll < 5 + w_ins)
                op = KIND_INSERT;
            else if (roll < 5 + w_ins + w_find)
                op = KIND_FIND;
            else
                op = KIND_DELETE;
            if ($urandom_range(0, 99) < 80)
                key = key_pool[$urandom_range(0, POOL_N - 1)];
            else
                key = KEY_W'($urandom);
            send_beat(op, key);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // Let the checker see the last beat, then wait for every answer.
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d inserts, %0d finds, %0d deletes, %0d unused-kind beats.",
                 inserts_sent, finds_sent, deletes_sent, unused_sent);
        $display("Answers: %0d success, %0d table full, %0d not found.",
                 ok_count, full_count, miss_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
